// ----- hw/rtl/resp_request_stream_parser_assert.svh -----
// ----------------------------------------------------------------------------
// resp_request_stream_parser_assert.svh
// assertion macros shared by the parser modules
// ----------------------------------------------------------------------------
`ifndef RESP_REQUEST_STREAM_PARSER_ASSERT_SVH
`define RESP_REQUEST_STREAM_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// expression holds at every edge out of reset
`define RRSP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define RRSP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define RRSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RRSP_ASSERT(lbl, clk, rst, prop)
`define RRSP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RRSP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/rrsp_pkg.sv -----
// ----------------------------------------------------------------------------
// rrsp_pkg
// types, codes and constants of the request stream parser
// ----------------------------------------------------------------------------
package rrsp_pkg;

  localparam int LEN_BITS_DEFAULT    = 31;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int VALUE_W             = 31;
  localparam int KIND_W              = 3;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [KIND_W-1:0] {
    KIND_COUNT = 3'd0,
    KIND_LEN   = 3'd1,
    KIND_BYTE  = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_NUM     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_TRAIL1  = 3'd3,
    PH_TRAIL2  = 3'd4,
    PH_ELEM    = 3'd5
  } phase_t;

  // classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic       is_space;
    logic       is_cr;
    logic       is_lf;
    logic       is_plus;
    logic       is_minus;
    logic       is_star;
    logic       is_dollar;
  } tok_t;

endpackage

// ----- hw/rtl/rrsp_byte_if.sv -----
// ----------------------------------------------------------------------------
// rrsp_byte_if
// valid/ready channel carrying one request byte per beat
// ----------------------------------------------------------------------------
interface rrsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- hw/rtl/rrsp_result_if.sv -----
// ----------------------------------------------------------------------------
// rrsp_result_if
// valid/ready channel carrying one parse result per beat
// ----------------------------------------------------------------------------
interface rrsp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [30:0] value;
  logic        message_end;

  modport source (output valid, output kind, output value, output message_end,
                  input ready);
  modport sink   (input valid, input kind, input value, input message_end,
                  output ready);
endinterface

// ----- hw/rtl/rrsp_front.sv -----
// ----------------------------------------------------------------------------
// rrsp_front
// accepts request bytes and classifies them for the parser back end
// ----------------------------------------------------------------------------
module rrsp_front
  import rrsp_pkg::*;
(
  rrsp_byte_if.sink stream,
  input  logic      queue_full,
  output logic      push,
  output tok_t      push_tok
);

  logic [7:0] b;

  assign b            = stream.in_byte;
  assign stream.ready = !queue_full;
  assign push         = stream.valid && !queue_full;

  always_comb begin
    push_tok.data      = b;
    push_tok.is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    // atoi white space: space, tab, lf, vt, ff, cr
    push_tok.is_space  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    push_tok.is_cr     = (b == CH_CR);
    push_tok.is_lf     = (b == CH_LF);
    push_tok.is_plus   = (b == CH_PLUS);
    push_tok.is_minus  = (b == CH_MINUS);
    push_tok.is_star   = (b == CH_STAR);
    push_tok.is_dollar = (b == CH_DOLLAR);
  end

endmodule

// ----- hw/rtl/rrsp_queue.sv -----
// ----------------------------------------------------------------------------
// rrsp_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
`include "resp_request_stream_parser_assert.svh"

module rrsp_queue
  import rrsp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output tok_t pop_tok,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_tok = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `RRSP_ASSERT(a_count_range, clk, rst, count <= CNT_W'(DEPTH))
  `RRSP_ASSERT_IMPL(a_no_overflow, clk, rst, push, !full)
  `RRSP_ASSERT_IMPL(a_no_underflow, clk, rst, pop, !empty)

endmodule

// ----- hw/rtl/rrsp_back.sv -----
// ----------------------------------------------------------------------------
// rrsp_back
// header, payload and trailer state machine with registered result beat
// ----------------------------------------------------------------------------
`include "resp_request_stream_parser_assert.svh"

module rrsp_back
  import rrsp_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  tok_t           tok,
  input  logic           tok_valid,
  output logic           pop,
  rrsp_result_if.source  result
);

  localparam int WIDE_W = LEN_BITS + 4;

  phase_t              phase, phase_next;
  logic [LEN_BITS-1:0] accum, accum_next;
  logic                f_lead, f_lead_next;
  logic                f_stop, f_stop_next;
  logic                f_neg, f_neg_next;
  logic                prev_cr, prev_cr_next;
  logic [LEN_BITS-1:0] elements_left, elements_left_next;
  logic [LEN_BITS-1:0] bytes_left, bytes_left_next;
  logic                in_array, in_array_next;
  logic                error_latched, error_latched_next;

  logic                out_valid;
  kind_t               out_kind;
  logic [VALUE_W-1:0]  out_value;
  logic                out_end;

  logic                take;
  logic                emit;
  kind_t               emit_kind;
  logic [VALUE_W-1:0]  emit_value;
  logic                emit_end;
  logic [WIDE_W-1:0]   acc_ext;
  logic [WIDE_W-1:0]   acc_step;

  assign take = tok_valid && (!out_valid || result.ready);
  assign pop  = take;

  // accum * 10 + digit, top four bits flag overflow
  assign acc_ext  = WIDE_W'(accum);
  assign acc_step = (acc_ext << 3) + (acc_ext << 1) + WIDE_W'(tok.data[3:0]);

  always_comb begin
    phase_next         = phase;
    accum_next         = accum;
    f_lead_next        = f_lead;
    f_stop_next        = f_stop;
    f_neg_next         = f_neg;
    prev_cr_next       = prev_cr;
    elements_left_next = elements_left;
    bytes_left_next    = bytes_left;
    in_array_next      = in_array;
    error_latched_next = error_latched;
    emit               = 1'b0;
    emit_kind          = KIND_ERR;
    emit_value         = '0;
    emit_end           = 1'b0;

    if (take && !error_latched) begin
      unique case (phase)
        PH_IDLE: begin
          if (tok.is_star || tok.is_dollar) begin
            in_array_next      = tok.is_star;
            elements_left_next = '0;
            phase_next         = PH_NUM;
            accum_next         = '0;
            f_lead_next        = 1'b0;
            f_stop_next        = 1'b0;
            f_neg_next         = 1'b0;
            prev_cr_next       = 1'b0;
          end else begin
            error_latched_next = 1'b1;
            emit               = 1'b1;
            emit_kind          = KIND_ERR;
          end
        end
        PH_ELEM: begin
          // first byte of an element header is skipped
          phase_next   = PH_NUM;
          accum_next   = '0;
          f_lead_next  = 1'b0;
          f_stop_next  = 1'b0;
          f_neg_next   = 1'b0;
          prev_cr_next = tok.is_cr;
        end
        PH_NUM: begin
          if (prev_cr && tok.is_lf) begin
            prev_cr_next = 1'b0;
            emit         = 1'b1;
            emit_value   = VALUE_W'(accum);
            if (in_array && (elements_left == '0)) begin
              emit_kind = KIND_COUNT;
              if (accum == '0) begin
                in_array_next = 1'b0;
                phase_next    = PH_IDLE;
                emit_end      = 1'b1;
              end else begin
                elements_left_next = accum;
                phase_next         = PH_ELEM;
              end
            end else begin
              emit_kind       = KIND_LEN;
              bytes_left_next = accum;
              phase_next      = (accum == '0) ? PH_TRAIL1 : PH_PAYLOAD;
            end
          end else begin
            prev_cr_next = tok.is_cr;
            if (f_stop) begin
              // number already ended, wait for crlf
            end else if (!f_lead && tok.is_space) begin
              // leading white space
            end else if (!f_lead && (tok.is_plus || tok.is_minus)) begin
              f_lead_next = 1'b1;
              f_neg_next  = f_neg || tok.is_minus;
            end else if (!tok.is_digit) begin
              f_lead_next = 1'b1;
              f_stop_next = 1'b1;
            end else begin
              f_lead_next = 1'b1;
              if ((f_neg && (acc_step != '0)) ||
                  (acc_step[WIDE_W-1:LEN_BITS] != '0)) begin
                error_latched_next = 1'b1;
                emit               = 1'b1;
                emit_kind          = KIND_ERR;
              end else begin
                accum_next = acc_step[LEN_BITS-1:0];
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (bytes_left <= LEN_BITS'(1)) begin
            bytes_left_next = '0;
            phase_next      = PH_TRAIL1;
          end else begin
            bytes_left_next = bytes_left - 1'b1;
          end
          emit       = 1'b1;
          emit_kind  = KIND_BYTE;
          emit_value = VALUE_W'(tok.data);
        end
        PH_TRAIL1: begin
          phase_next = PH_TRAIL2;
        end
        PH_TRAIL2: begin
          emit      = 1'b1;
          emit_kind = KIND_END;
          if (in_array && (elements_left > LEN_BITS'(1))) begin
            elements_left_next = elements_left - 1'b1;
            phase_next         = PH_ELEM;
          end else begin
            elements_left_next = '0;
            in_array_next      = 1'b0;
            phase_next         = PH_IDLE;
            emit_end           = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      accum         <= '0;
      f_lead        <= 1'b0;
      f_stop        <= 1'b0;
      f_neg         <= 1'b0;
      prev_cr       <= 1'b0;
      elements_left <= '0;
      bytes_left    <= '0;
      in_array      <= 1'b0;
      error_latched <= 1'b0;
    end else begin
      phase         <= phase_next;
      accum         <= accum_next;
      f_lead        <= f_lead_next;
      f_stop        <= f_stop_next;
      f_neg         <= f_neg_next;
      prev_cr       <= prev_cr_next;
      elements_left <= elements_left_next;
      bytes_left    <= bytes_left_next;
      in_array      <= in_array_next;
      error_latched <= error_latched_next;
    end
  end

  // output register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind  <= emit_kind;
      out_value <= emit_value;
      out_end   <= emit_end;
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.value       = out_value;
  assign result.message_end = out_end;

  `RRSP_ASSERT_IMPL(a_single_has_no_elems, clk, rst, !in_array, elements_left == '0)
  `RRSP_ASSERT_IMPL(a_elem_in_array, clk, rst, phase == PH_ELEM,
                    in_array && (elements_left != '0))
  `RRSP_ASSERT_NEXT(a_quiet_after_error, clk, rst,
                    error_latched && !(out_valid && !result.ready), !out_valid)
  `RRSP_ASSERT_IMPL(a_error_no_end, clk, rst, out_valid && (out_kind == KIND_ERR),
                    !out_end && (out_value == '0))

endmodule

// ----- hw/rtl/resp_request_stream_parser.sv -----
// ----------------------------------------------------------------------------
// resp_request_stream_parser
// streaming parser for client request messages (bulk strings and arrays)
//
// stream: one raw request byte per beat, valid/ready.
// result: one parse event per beat: array count, bulk length, payload byte,
//   element end or error, with message_end on the last event of a message.
// a byte accepted from stream passes through the byte queue and the back-end
//   state machine into the registered result beat; bytes that only advance
//   the header, and the first trailer byte, give no result.
// throughput is one byte per cycle while result does not stall; the back-end
//   state machine takes one step per byte (header digit accumulate is a shift-add per byte).
// a two-entry byte queue sits between the classifier and the state machine;
//   when result stalls the output register holds, the back end stops, the
//   queue fills and stream.ready drops once it is full.
// after an error result, every later byte is accepted and dropped until rst.
// rst (synchronous) empties the queue, drops any pending result and returns
//   the parser to waiting for a type byte with the error flag cleared.
// ----------------------------------------------------------------------------
module resp_request_stream_parser
  import rrsp_pkg::*;
#(
  parameter int LEN_BITS    = LEN_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  rrsp_byte_if.sink     stream,
  rrsp_result_if.source result
);

  logic push;
  tok_t push_tok;
  logic queue_full;
  logic pop;
  tok_t pop_tok;
  logic queue_empty;

  rrsp_front u_front (
    .stream     (stream),
    .queue_full (queue_full),
    .push       (push),
    .push_tok   (push_tok)
  );

  rrsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .full     (queue_full),
    .pop      (pop),
    .pop_tok  (pop_tok),
    .empty    (queue_empty)
  );

  rrsp_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (pop_tok),
    .tok_valid (!queue_empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the request stream parser
//
// builds a byte stream of well-formed bulk strings and arrays with random
// header spelling, payloads and trailers, then closes with one error case,
// since an error stays latched until reset. a predictor follows every
// accepted byte and queues the parse events it implies; the monitor checks
// each result beat against the oldest queued event. both channels idle and
// stall at random, the result side holds off for a long stretch once, and
// the stream side pauses once until every queued event has arrived.
// ----------------------------------------------------------------------------
module tb_top;
  import rrsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_BYTES = 1150;
  localparam int CALM_TAIL = 150;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_AT = 650;
  localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS_DEFAULT) - 1;

  typedef enum int {
    TAIL_BAD_TYPE,
    TAIL_NEGATIVE,
    TAIL_OVERFLOW
  } tail_case_t;

  typedef struct packed {
    kind_t       kind;
    logic [30:0] value;
    logic        msg_end;
  } parse_ev_t;

  typedef struct {
    logic [7:0] data;
    bit         drain;
  } tx_beat_t;

  typedef logic [7:0] byte_list_t[];

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrsp_byte_if   stream_ch ();
  rrsp_result_if result_ch ();

  resp_request_stream_parser dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch)
  );

  always #2 clk = ~clk;

  tx_beat_t   tx_bytes[$];
  parse_ev_t  pending_events[$];
  int         outstanding = 0;
  int         bytes_accepted = 0;
  int         events_checked = 0;
  int         fail_count = 0;
  int         msg_count = 0;
  int         total_bytes = 0;
  bit         calm = 1'b0;
  bit         hold_off = 1'b0;
  bit         pause_pending = 1'b0;
  bit         drain_done = 1'b0;
  logic [7:0] last_pushed = 8'h00;
  tail_case_t tail_case;

  // ---------------------------------------------------------------------------
  // predictor state
  // ---------------------------------------------------------------------------
  phase_t      ph;
  logic [30:0] num_acc;
  logic        num_lead, num_stop, num_neg;
  logic        hdr_prev_cr;
  logic [30:0] elems_left, payload_left;
  logic        in_arr, err_seen;

  function automatic void expect_event(kind_t k, logic [30:0] v, logic e);
    pending_events.push_back('{kind: k, value: v, msg_end: e});
  endfunction

  function automatic void flag_error();
    err_seen = 1'b1;
    expect_event(KIND_ERR, '0, 1'b0);
  endfunction

  function automatic void open_number(logic after_cr);
    ph = PH_NUM;
    num_acc = '0;
    num_lead = 1'b0;
    num_stop = 1'b0;
    num_neg = 1'b0;
    hdr_prev_cr = after_cr;
  endfunction

  function automatic void close_element();
    if (in_arr && elems_left > 1) begin
      elems_left = elems_left - 1;
      ph = PH_ELEM;
      expect_event(KIND_END, '0, 1'b0);
    end else begin
      elems_left = '0;
      in_arr = 1'b0;
      ph = PH_IDLE;
      expect_event(KIND_END, '0, 1'b1);
    end
  endfunction

  function automatic void line_done();
    hdr_prev_cr = 1'b0;
    if (in_arr && elems_left == 0) begin
      if (num_acc == 0) begin
        in_arr = 1'b0;
        ph = PH_IDLE;
        expect_event(KIND_COUNT, '0, 1'b1);
      end else begin
        elems_left = num_acc;
        ph = PH_ELEM;
        expect_event(KIND_COUNT, num_acc, 1'b0);
      end
    end else begin
      payload_left = num_acc;
      ph = (num_acc == 0) ? PH_TRAIL1 : PH_PAYLOAD;
      expect_event(KIND_LEN, num_acc, 1'b0);
    end
  endfunction

  function automatic void header_byte(logic [7:0] b);
    logic [63:0] nxt;
    logic        is_digit;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    if (hdr_prev_cr && b == CH_LF) begin
      line_done();
      return;
    end
    hdr_prev_cr = (b == CH_CR);
    if (num_stop)
      return;
    if (!num_lead) begin
      if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
        return;
      if (b == CH_PLUS || b == CH_MINUS) begin
        num_lead = 1'b1;
        num_neg = (b == CH_MINUS);
        return;
      end
    end
    if (!is_digit) begin
      num_lead = 1'b1;
      num_stop = 1'b1;
      return;
    end
    num_lead = 1'b1;
    nxt = 64'(num_acc) * 64'd10 + 64'(b - CH_ZERO);
    // minus only survives while the digits stay zero
    if ((num_neg && nxt != 0) || nxt > LEN_MAX) begin
      flag_error();
      return;
    end
    num_acc = nxt[30:0];
  endfunction

  function automatic void parse_step(logic [7:0] b);
    if (err_seen)
      return;
    case (ph)
      PH_IDLE: begin
        if (b == CH_STAR || b == CH_DOLLAR) begin
          in_arr = (b == CH_STAR);
          elems_left = '0;
          open_number(1'b0);
        end else begin
          flag_error();
        end
      end
      PH_ELEM: open_number(b == CH_CR);
      PH_NUM: header_byte(b);
      PH_PAYLOAD: begin
        if (payload_left <= 1) begin
          payload_left = '0;
          ph = PH_TRAIL1;
        end else begin
          payload_left = payload_left - 1;
        end
        expect_event(KIND_BYTE, 31'(b), 1'b0);
      end
      PH_TRAIL1: ph = PH_TRAIL2;
      PH_TRAIL2: close_element();
      default: ph = PH_IDLE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------
  task automatic push(logic [7:0] b);
    tx_bytes.push_back('{data: b, drain: pause_pending});
    pause_pending = 1'b0;
    last_pushed = b;
  endtask

  // header text never lets a stray cr lf end the line early
  task automatic push_text(logic [7:0] b);
    if (b == CH_LF && last_pushed == CH_CR)
      b = CH_SPACE;
    push(b);
  endtask

  task automatic push_list(byte_list_t bl);
    foreach (bl[i])
      push(bl[i]);
  endtask

  task automatic push_digits(string s);
    for (int i = 0; i < s.len(); i++)
      push(8'(s[i]));
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_stop();
    logic [7:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (b >= CH_ZERO && b <= CH_NINE);
    return b;
  endfunction

  function automatic int unsigned pick_len();
    if ($urandom_range(0, 19) == 0)
      return $urandom_range(13, 200);
    return $urandom_range(0, 12);
  endfunction

  task automatic gen_header(int unsigned n);
    string       digs;
    bit          led;
    int unsigned pick;
    led = 1'b0;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_text(pick_space());
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      push(CH_PLUS);
      led = 1'b1;
    end else if (pick == 1 && n == 0) begin
      push(CH_MINUS);
      led = 1'b1;
    end
    if (n == 0 && $urandom_range(0, 2) == 0) begin
      digs = "";
    end else begin
      digs = $sformatf("%0d", n);
      if ($urandom_range(0, 3) == 0)
        digs = {"00", digs};
      led = 1'b1;
    end
    push_digits(digs);
    // trailing junk after the number stops is ignored up to cr lf
    if (led && $urandom_range(0, 4) == 0) begin
      push(pick_stop());
      repeat ($urandom_range(0, 3)) push_text(8'($urandom_range(0, 255)));
    end
    push(CH_CR);
    push(CH_LF);
  endtask

  task automatic gen_bulk(bit in_elem, int unsigned len);
    if (in_elem && len == 0 && $urandom_range(0, 3) == 0) begin
      push(CH_CR);
      push(CH_LF);
    end else begin
      if (!in_elem || $urandom_range(0, 3) != 0)
        push(CH_DOLLAR);
      else
        push(8'($urandom_range(0, 255)));
      gen_header(len);
    end
    repeat (len) push(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      push(8'($urandom_range(0, 255)));
      push(8'($urandom_range(0, 255)));
    end else begin
      push(CH_CR);
      push(CH_LF);
    end
  endtask

  task automatic gen_message();
    int unsigned cnt;
    msg_count++;
    if ($urandom_range(0, 2) == 0) begin
      gen_bulk(1'b0, pick_len());
    end else begin
      cnt = $urandom_range(0, 5);
      push(CH_STAR);
      gen_header(cnt);
      repeat (cnt) gen_bulk(1'b1, pick_len());
    end
  endtask

  task automatic gen_tail();
    logic [7:0] b;
    tail_case = tail_case_t'($urandom_range(0, 2));
    msg_count++;
    if (tail_case == TAIL_BAD_TYPE) begin
      do
        b = 8'($urandom_range(0, 255));
      while (b == CH_STAR || b == CH_DOLLAR);
      push(b);
    end else begin
      // largest count, two elements, then a header that must fail
      push(CH_STAR);
      gen_header(int'(LEN_MAX));
      gen_bulk(1'b1, pick_len());
      gen_bulk(1'b1, pick_len());
      push(CH_DOLLAR);
      if (tail_case == TAIL_NEGATIVE) begin
        push(CH_MINUS);
        if ($urandom_range(0, 1) == 0)
          push(CH_ZERO);
        push(CH_ZERO + 8'($urandom_range(1, 9)));
      end else begin
        push_digits($sformatf("%0d", LEN_MAX + 1 + $urandom_range(0, 1000)));
      end
    end
    // everything after the error is swallowed
    repeat (20) push(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // stream driver
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      stream_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (tx_bytes.size() < CALM_TAIL)
        calm <= 1'b1;
      if (!(stream_ch.valid && !stream_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          stream_ch.valid <= 1'b0;
        end else if (tx_bytes.size() == 0) begin
          stream_ch.valid <= 1'b0;
        end else if (tx_bytes[0].drain && (outstanding != 0 || stream_ch.valid)) begin
          // a byte taken at this edge is not yet in the outstanding count
          stream_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(1, 14) - 1;
          stream_ch.valid <= 1'b0;
        end else begin
          stream_ch.valid <= 1'b1;
          stream_ch.in_byte <= tx_bytes.pop_front().data;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and checker
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  function automatic void check_result();
    parse_ev_t want;
    if (pending_events.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%t unexpected result: kind %0d value %0d end %0d", $realtime,
                 result_ch.kind, result_ch.value, result_ch.message_end);
      return;
    end
    want = pending_events.pop_front();
    events_checked++;
    if (result_ch.kind !== want.kind || result_ch.value !== want.value ||
        result_ch.message_end !== want.msg_end) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%t mismatch: expected %s value %0d end %0d, got kind %0d value %0d end %0d",
                 $realtime, want.kind.name(), want.value, want.msg_end,
                 result_ch.kind, result_ch.value, result_ch.message_end);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      // results always trail their byte, so check before predicting
      if (result_ch.valid && result_ch.ready)
        check_result();
      if (stream_ch.valid && stream_ch.ready) begin
        parse_step(stream_ch.in_byte);
        bytes_accepted++;
      end
      outstanding <= pending_events.size();
      if (hold_off) begin
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // long back-pressure stretch so the parser queue fills and stream stalls
  initial begin
    while (bytes_accepted < HOLD_AFTER)
      @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2ms;
    $display("timeout waiting for the parser");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stream_ch.valid = 1'b0;
    stream_ch.in_byte = 8'h00;
    result_ch.ready = 1'b0;

    ph = PH_IDLE;
    num_acc = '0;
    num_lead = 1'b0;
    num_stop = 1'b0;
    num_neg = 1'b0;
    hdr_prev_cr = 1'b0;
    elems_left = '0;
    payload_left = '0;
    in_arr = 1'b0;
    err_seen = 1'b0;

    // zero count array
    push_list('{CH_STAR, CH_ZERO, CH_CR, CH_LF});
    // white space, minus zero, zero length bulk
    push_list('{CH_DOLLAR, CH_TAB, CH_MINUS, CH_ZERO, CH_CR, CH_LF, CH_CR, CH_LF});
    // one element whose header is empty
    push_list('{CH_STAR, 8'h31, CH_CR, CH_LF, CH_CR, CH_LF, 8'hFF, 8'h00});
    // plus sign, digits cut short by a letter, one payload beat
    push_list('{CH_DOLLAR, CH_PLUS, 8'h31, 8'h78, 8'h39, CH_CR, CH_LF, 8'h80,
                CH_CR, CH_LF});
    msg_count = 4;

    while (tx_bytes.size() < TARGET_BYTES) begin
      if (tx_bytes.size() > DRAIN_AT && !drain_done) begin
        pause_pending = 1'b1;
        drain_done = 1'b1;
      end
      gen_message();
    end
    gen_tail();
    total_bytes = tx_bytes.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (bytes_accepted < total_bytes)
      @(posedge clk);
    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    if (pending_events.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", pending_events.size());
    end
    $display("stream of %0d bytes in %0d messages, %0d parse events matched",
             total_bytes, msg_count, events_checked);
    $display("closing case %s, %0d mismatches", tail_case.name(), fail_count);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
